>>> rtl/krb_pkg.sv
// Shared types and constants for the keyboard report builder.
// Used by krb_ctrl, krb_datapath and keyboard_report_builder; no dependencies.
package krb_pkg;

  // Slot storage and report layout
  localparam int SLOT_COUNT = 6;
  localparam int OUT_SLOTS  = 6;
  localparam int KEY_W      = 8;
  localparam int REP_W      = 4;

  localparam logic [REP_W-1:0] REPEAT_RESET = 4'd3;

  // Modifier keys occupy usage codes 0xE0..0xE7
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  // Operation codes
  localparam logic [1:0] OP_PRESS       = 2'd0;
  localparam logic [1:0] OP_RELEASE     = 2'd1;
  localparam logic [1:0] OP_RELEASE_ALL = 2'd2;
  localparam logic [1:0] OP_POLL        = 2'd3;

  // Input word
  typedef struct packed {
    logic [1:0]       operation;
    logic [KEY_W-1:0] key;
  } krb_in_t;

  // Report word
  typedef struct packed {
    logic [7:0]       modifier_bits;
    logic [KEY_W-1:0] slot_key_0;
    logic [KEY_W-1:0] slot_key_1;
    logic [KEY_W-1:0] slot_key_2;
    logic [KEY_W-1:0] slot_key_3;
    logic [KEY_W-1:0] slot_key_4;
    logic [KEY_W-1:0] slot_key_5;
  } krb_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input word
    logic exec;    // apply the captured word to the key state
    logic cfg_we;  // write repeat count
  } krb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic report_due;  // captured word is a poll and sends are pending
  } krb_status_t;

endpackage

>>> rtl/keyboard_report_builder.sv
// Keyboard report builder: six-key-rollover report with modifier mask.
// Sequencing: an accepted word is captured in idle and applied in execute; a due
// poll's report is registered and strobes out_valid for one cycle as it is applied.
// A new word is not taken while busy, that is while the last one executes.
// Reset (synchronous, rst_n low): slots, modifiers and pending sends cleared,
// repeat count 3. Results cannot be stalled by the receiver.
module keyboard_report_builder import krb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  krb_in_t          in_item,
  output logic             out_valid,
  output krb_out_t         out_report,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [REP_W-1:0] cfg_data
);

  krb_cmd_t    cmd;
  krb_status_t status;

  krb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .status    (status),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  krb_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .cfg_data   (cfg_data),
    .status     (status),
    .out_report (out_report)
  );

endmodule

>>> rtl/krb_ctrl.sv
// Controller for the keyboard report builder: idle/execute sequencing,
// result strobe and configuration handshake. Depends on krb_pkg.
module krb_ctrl import krb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        cfg_valid,
  input  krb_status_t status,
  output logic        busy,
  output logic        cfg_ready,
  output logic        out_valid,
  output krb_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // Next state and strobe
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        out_valid_nxt = status.report_due;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Handshake and datapath commands
  assign busy       = (state_r == ST_EXEC);
  assign cfg_ready  = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = (state_r == ST_IDLE) && start;
  assign cmd.exec   = (state_r == ST_EXEC);
  assign cmd.cfg_we = cfg_valid && cfg_ready;

  // Checks
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> state_r == ST_IDLE)
    else $error("execute state held more than one cycle");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC) && $past(status.report_due))
    else $error("result strobe without a due poll");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == ST_EXEC)
    else $error("accepted word did not enter execute");

endmodule

>>> rtl/krb_datapath.sv
// Datapath for the keyboard report builder: modifier mask, key slots,
// pending-send counter, repeat count and report register. Depends on krb_pkg.
module krb_datapath import krb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  krb_cmd_t    cmd,
  input  krb_in_t     in_item,
  input  logic [REP_W-1:0] cfg_data,
  output krb_status_t status,
  output krb_out_t    out_report
);

  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [REP_W-1:0] repeat_r;
  logic [REP_W-1:0] pend_r, pend_nxt;
  logic [7:0]       mod_r, mod_nxt;
  logic [KEY_W-1:0] slots_r   [SLOT_COUNT];
  logic [KEY_W-1:0] slots_nxt [SLOT_COUNT];
  krb_out_t         report_r;

  logic [SLOT_COUNT-1:0] hit, free, first_hit, first_free;
  logic                  is_mod, key_zero, changed, report_due;
  logic [7:0]            mod_bit;
  logic [KEY_W-1:0]      rpt_slot [OUT_SLOTS];

  // Input word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_item.operation;
      key_r <= in_item.key;
    end
  end

  // Parallel slot compares
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i]  = (slots_r[i] == key_r);
      free[i] = (slots_r[i] == '0);
    end
  end

  // Lowest set bit picks the first matching or empty slot
  assign first_hit  = hit & ~(hit - SLOT_COUNT'(1));
  assign first_free = free & ~(free - SLOT_COUNT'(1));

  assign is_mod     = (key_r[7:3] == MOD_PREFIX);
  assign key_zero   = (key_r == '0);
  assign mod_bit    = 8'd1 << key_r[2:0];
  assign report_due = (op_r == OP_POLL) && (pend_r != '0);

  // Key state update
  always_comb begin
    mod_nxt = mod_r;
    changed = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) slots_nxt[i] = slots_r[i];
    unique case (op_r)
      OP_PRESS: begin
        if (is_mod) begin
          mod_nxt = mod_r | mod_bit;
          changed = ((mod_r & mod_bit) == '0);
        end else if (!key_zero && (hit == '0) && (free != '0)) begin
          changed = 1'b1;
          for (int i = 0; i < SLOT_COUNT; i++)
            if (first_free[i]) slots_nxt[i] = key_r;
        end
      end
      OP_RELEASE: begin
        if (is_mod) begin
          mod_nxt = mod_r & ~mod_bit;
          changed = ((mod_r & mod_bit) != '0);
        end else if (!key_zero && (hit != '0)) begin
          changed = 1'b1;
          for (int i = 0; i < SLOT_COUNT; i++)
            if (first_hit[i]) slots_nxt[i] = '0;
        end
      end
      OP_RELEASE_ALL: begin
        changed = (free != '1);
        for (int i = 0; i < SLOT_COUNT; i++) slots_nxt[i] = '0;
      end
      OP_POLL: begin
        changed = 1'b0;
      end
      default: changed = 1'b0;
    endcase
  end

  // Pending-send counter
  always_comb begin
    pend_nxt = pend_r;
    if (changed)         pend_nxt = repeat_r;
    else if (report_due) pend_nxt = pend_r - REP_W'(1);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_r <= REPEAT_RESET;
      pend_r   <= '0;
      mod_r    <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) slots_r[i] <= '0;
    end else begin
      if (cmd.cfg_we) repeat_r <= cfg_data;
      if (cmd.exec) begin
        pend_r <= pend_nxt;
        mod_r  <= mod_nxt;
        for (int i = 0; i < SLOT_COUNT; i++) slots_r[i] <= slots_nxt[i];
      end
    end
  end

  // Report slots beyond the stored count read as empty
  for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_rpt
    if (g < SLOT_COUNT) begin : g_used
      assign rpt_slot[g] = slots_r[g];
    end else begin : g_empty
      assign rpt_slot[g] = '0;
    end
  end

  // Report register, loaded on a due poll
  always_ff @(posedge clk) begin
    if (cmd.exec && report_due) begin
      report_r.modifier_bits <= mod_r;
      report_r.slot_key_0    <= rpt_slot[0];
      report_r.slot_key_1    <= rpt_slot[1];
      report_r.slot_key_2    <= rpt_slot[2];
      report_r.slot_key_3    <= rpt_slot[3];
      report_r.slot_key_4    <= rpt_slot[4];
      report_r.slot_key_5    <= rpt_slot[5];
    end
  end

  assign status.report_due = report_due;
  assign out_report        = report_r;

  // Checks
  a_poll_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && report_due |=> pend_r == $past(pend_r) - REP_W'(1))
    else $error("due poll did not decrement pending sends");

  a_mod_press_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_r == OP_PRESS && is_mod |=> (mod_r & $past(mod_bit)) != '0)
    else $error("modifier press did not set its bit");

  a_release_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_r == OP_RELEASE_ALL |=> slots_r[0] == '0)
    else $error("release-all left slot 0 occupied");

endmodule
